@@ sv/svpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared constants, types and the CORDIC arctangent table of the SVPWM core.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  localparam int ANGLE_BITS_DFLT = 16;
  localparam int CORDIC_STEPS    = 30;
  localparam int SQRT_STAGES     = 32;
  localparam int DIV_STAGES      = 16;
  // squares, sum, root stages, divide setup, divide stages, clip
  localparam int MAG_LAT         = SQRT_STAGES + DIV_STAGES + 4;
  localparam int ATAN_LAT        = CORDIC_STEPS + 1;
  localparam int SIN_LAT         = CORDIC_STEPS + 1;

  localparam logic [15:0] BUS_VOLTAGE_RST = 16'd12288;
  localparam logic [15:0] MAX_MOD_RST     = 16'd36504;
  localparam logic [15:0] PWM_TOP_RST     = 16'd1799;
  localparam logic [9:0]  D_BAND_RST      = 10'd10;

  localparam logic [30:0] CORDIC_GAIN_Q30 = 31'd652032874;
  localparam logic [30:0] SQRT3_Q30       = 31'd1859775393;
  localparam logic [31:0] RECIP3          = 32'hAAAAAAAB;

  typedef enum logic [1:0] {
    REG_BUS_VOLTAGE = 2'd0,
    REG_MAX_MOD     = 2'd1,
    REG_PWM_TOP     = 2'd2,
    REG_D_BAND      = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    SEC_NONE = 3'd0,
    SEC_1    = 3'd1,
    SEC_2    = 3'd2,
    SEC_3    = 3'd3,
    SEC_4    = 3'd4,
    SEC_5    = 3'd5,
    SEC_6    = 3'd6
  } sector_t;

  typedef struct packed {
    logic [15:0] mag;
    logic        clipped;
  } mag_res_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051E;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2FA;
      15:      v = 32'h0000517D;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A30;
      19:      v = 32'h00000518;
      20:      v = 32'h0000028C;
      21:      v = 32'h00000146;
      22:      v = 32'h000000A3;
      23:      v = 32'h00000051;
      24:      v = 32'h00000029;
      25:      v = 32'h00000014;
      26:      v = 32'h0000000A;
      27:      v = 32'h00000005;
      28:      v = 32'h00000003;
      29:      v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

@@ sv/svpwm_mag.sv @@
// ----------------------------------------------------------------------------
// svpwm_mag
// Pipelined modulation magnitude: floor(sqrt((q^2 + d^2) << 32)) / bus,
// saturated at max_modulation. One root bit and one quotient bit per stage.
// ----------------------------------------------------------------------------
module svpwm_mag (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  logic signed [15:0]    in_vq,
  input  logic signed [15:0]    in_vd,
  input  logic [15:0]           bus_voltage,
  input  logic [15:0]           max_modulation,
  output logic                  out_vld,
  output svpwm_pkg::mag_res_t   out_res
);

  localparam int NR = svpwm_pkg::SQRT_STAGES;
  localparam int ND = svpwm_pkg::DIV_STAGES;

  logic signed [31:0] pq, pd;
  logic [30:0]        sqq_r, sqd_r;
  logic               sq_vld_r;

  logic [35:0]        rt_rem_r  [0:NR-1];
  logic [31:0]        rt_sq_r   [0:NR-1];
  logic [31:0]        rt_root_r [0:NR];
  logic [NR:0]        rt_vld_r;

  logic [15:0]        bus_eff;
  logic [15:0]        dv_rem_r [0:ND-1];
  logic [15:0]        dv_low_r [0:ND-1];
  logic [15:0]        dv_q_r   [0:ND];
  logic [ND:0]        dv_ovf_r;
  logic [ND:0]        dv_vld_r;

  svpwm_pkg::mag_res_t res_r;
  logic                res_vld_r;

  assign pq = in_vq * in_vq;
  assign pd = in_vd * in_vd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r    <= 1'b0;
      rt_vld_r[0] <= 1'b0;
    end else begin
      sq_vld_r    <= in_vld;
      rt_vld_r[0] <= sq_vld_r;
    end
    sqq_r        <= pq[30:0];
    sqd_r        <= pd[30:0];
    rt_sq_r[0]   <= {1'b0, sqq_r} + {1'b0, sqd_r};
    rt_rem_r[0]  <= '0;
    rt_root_r[0] <= '0;
  end

  // digit-by-digit root; the low 32 radicand bits are zero
  for (genvar k = 0; k < NR; k++) begin : g_rt
    logic [35:0] rem_sh, trial, rem_nxt;
    logic [31:0] root_nxt;
    logic        fit;

    always_comb begin
      rem_sh   = {rt_rem_r[k][33:0], rt_sq_r[k][31:30]};
      trial    = {2'b00, rt_root_r[k], 2'b01};
      fit      = (rem_sh >= trial);
      rem_nxt  = fit ? (rem_sh - trial) : rem_sh;
      root_nxt = {rt_root_r[k][30:0], fit};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_vld_r[k+1] <= 1'b0;
      end else begin
        rt_vld_r[k+1] <= rt_vld_r[k];
      end
      rt_root_r[k+1] <= root_nxt;
    end

    if (k + 1 < NR) begin : g_carry
      always_ff @(posedge clk) begin
        rt_rem_r[k+1] <= rem_nxt;
        rt_sq_r[k+1]  <= {rt_sq_r[k][29:0], 2'b00};
      end
    end
  end

  assign bus_eff = (bus_voltage == 16'd0) ? 16'd1 : bus_voltage;

  // quotient above 16 bits means the result saturates anyway
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else begin
      dv_vld_r[0] <= rt_vld_r[NR];
    end
    dv_rem_r[0] <= rt_root_r[NR][31:16];
    dv_low_r[0] <= rt_root_r[NR][15:0];
    dv_q_r[0]   <= '0;
    dv_ovf_r[0] <= (rt_root_r[NR][31:16] >= bus_eff);
  end

  for (genvar j = 0; j < ND; j++) begin : g_dv
    logic [16:0] rem_sh, diff;
    logic        fit;

    always_comb begin
      rem_sh = {dv_rem_r[j], dv_low_r[j][15]};
      diff   = rem_sh - {1'b0, bus_eff};
      fit    = (rem_sh >= {1'b0, bus_eff});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j+1] <= 1'b0;
      end else begin
        dv_vld_r[j+1] <= dv_vld_r[j];
      end
      dv_q_r[j+1]   <= {dv_q_r[j][14:0], fit};
      dv_ovf_r[j+1] <= dv_ovf_r[j];
    end

    if (j + 1 < ND) begin : g_carry
      always_ff @(posedge clk) begin
        dv_rem_r[j+1] <= fit ? diff[15:0] : rem_sh[15:0];
        dv_low_r[j+1] <= {dv_low_r[j][14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= dv_vld_r[ND];
    end
    if (dv_ovf_r[ND] || (dv_q_r[ND] > max_modulation)) begin
      res_r.mag     <= max_modulation;
      res_r.clipped <= 1'b1;
    end else begin
      res_r.mag     <= dv_q_r[ND];
      res_r.clipped <= 1'b0;
    end
  end

  assign out_vld = res_vld_r;
  assign out_res = res_r;

endmodule

@@ sv/svpwm_atan.sv @@
// ----------------------------------------------------------------------------
// svpwm_atan
// Pipelined vectoring CORDIC: atan2(q, d) in 2^-32 turn, one step per stage.
// ----------------------------------------------------------------------------
module svpwm_atan (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [15:0] in_vq,
  input  logic signed [15:0] in_vd,
  output logic               out_vld,
  output logic [31:0]        out_turn
);

  localparam int NS = svpwm_pkg::CORDIC_STEPS;

  logic signed [35:0] x_r [0:NS-1];
  logic signed [35:0] y_r [0:NS-1];
  logic [31:0]        z_r [0:NS];
  logic [NS:0]        zero_r;
  logic [NS:0]        vld_r;

  logic signed [35:0] xs, ys;

  assign xs = {{4{in_vd[15]}}, in_vd, 16'h0000};
  assign ys = {{4{in_vq[15]}}, in_vq, 16'h0000};

  // left half plane: rotate by half a turn first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    zero_r[0] <= (in_vq == 16'sd0) && (in_vd == 16'sd0);
    if (in_vd[15]) begin
      x_r[0] <= -xs;
      y_r[0] <= -ys;
      z_r[0] <= 32'h80000000;
    end else begin
      x_r[0] <= xs;
      y_r[0] <= ys;
      z_r[0] <= 32'h00000000;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    logic signed [35:0] dx, dy, x_nxt, y_nxt;
    logic [31:0]        z_nxt;

    always_comb begin
      dx = y_r[i] >>> i;
      dy = x_r[i] >>> i;
      if (y_r[i][35]) begin
        x_nxt = x_r[i] - dx;
        y_nxt = y_r[i] + dy;
        z_nxt = z_r[i] - svpwm_pkg::atan_turn(i);
      end else begin
        x_nxt = x_r[i] + dx;
        y_nxt = y_r[i] - dy;
        z_nxt = z_r[i] + svpwm_pkg::atan_turn(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      z_r[i+1]    <= z_nxt;
      zero_r[i+1] <= zero_r[i];
    end

    if (i + 1 < NS) begin : g_carry
      always_ff @(posedge clk) begin
        x_r[i+1] <= x_nxt;
        y_r[i+1] <= y_nxt;
      end
    end
  end

  assign out_vld  = vld_r[NS];
  assign out_turn = zero_r[NS] ? 32'h00000000 : z_r[NS];

endmodule

@@ sv/svpwm_sin.sv @@
// ----------------------------------------------------------------------------
// svpwm_sin
// Pipelined rotation CORDIC: sine of an angle in 2^-32 turn, Q1.30,
// negative results clamped to zero.
// ----------------------------------------------------------------------------
module svpwm_sin (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [31:0] in_turn,
  output logic        out_vld,
  output logic [30:0] out_sin
);

  localparam int NS = svpwm_pkg::CORDIC_STEPS;

  logic signed [32:0] x_r [0:NS-1];
  logic signed [32:0] y_r [0:NS];
  logic signed [33:0] z_r [0:NS-1];
  logic [NS:0]        vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    x_r[0] <= {2'b00, svpwm_pkg::CORDIC_GAIN_Q30};
    y_r[0] <= '0;
    z_r[0] <= {2'b00, in_turn};
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    logic signed [32:0] dx, dy, x_nxt, y_nxt;
    logic signed [33:0] z_nxt, at;

    always_comb begin
      dx = y_r[i] >>> i;
      dy = x_r[i] >>> i;
      at = {2'b00, svpwm_pkg::atan_turn(i)};
      if (!z_r[i][33]) begin
        x_nxt = x_r[i] - dx;
        y_nxt = y_r[i] + dy;
        z_nxt = z_r[i] - at;
      end else begin
        x_nxt = x_r[i] + dx;
        y_nxt = y_r[i] - dy;
        z_nxt = z_r[i] + at;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      y_r[i+1] <= y_nxt;
    end

    if (i + 1 < NS) begin : g_carry
      always_ff @(posedge clk) begin
        x_r[i+1] <= x_nxt;
        z_r[i+1] <= z_nxt;
      end
    end
  end

  assign out_vld = vld_r[NS];
  assign out_sin = y_r[NS][32] ? 31'd0 : y_r[NS][30:0];

endmodule

@@ sv/svpwm_duty_from_dq_voltage_core.sv @@
// ----------------------------------------------------------------------------
// svpwm_duty_from_dq_voltage_core
// Space vector PWM compare values from a dq voltage request and an
// electrical angle: inverse Park, magnitude, sector and dwell times.
// ----------------------------------------------------------------------------
// One request is taken per clock (start while busy is low) and its result
// appears on out_valid for a single cycle; there is no backpressure, so
// the receiver must take every result. Each request passes through the
// magnitude chain (32 square-root stages and 16 divide stages), then the
// sector logic, a 30-step sine CORDIC and the dwell-time and compare
// multipliers. busy is set by reset and cleared once reset is released.
// ----------------------------------------------------------------------------
module svpwm_duty_from_dq_voltage_core #(
  parameter int ANGLE_BITS = svpwm_pkg::ANGLE_BITS_DFLT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_volt_q,
  input  logic signed [15:0] in_volt_d,
  input  logic [15:0]        in_elec_angle,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata,
  output logic               out_valid,
  output logic [15:0]        out_compare_a,
  output logic [15:0]        out_compare_b,
  output logic [15:0]        out_compare_c,
  output logic [2:0]         out_sector_num,
  output logic               out_magnitude_clipped
);

  localparam int AB       = ANGLE_BITS;
  localparam int MAG_LAT  = svpwm_pkg::MAG_LAT;
  localparam int SIN_LAT  = svpwm_pkg::SIN_LAT;
  localparam int ZD       = svpwm_pkg::MAG_LAT - svpwm_pkg::ATAN_LAT;
  localparam int PIPE_LAT = 1 + MAG_LAT + 2 + SIN_LAT + 5;
  localparam int SW       = AB + 2;
  localparam int NW       = 3 + $bits(svpwm_pkg::mag_res_t);

  localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);
  localparam logic [31:0]   ZRND    = 32'd1 << (31 - AB);

  // configuration
  logic [15:0] bus_voltage_r, max_mod_r, pwm_top_r;
  logic [9:0]  d_band_r;
  logic        busy_r;
  logic        accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_voltage_r <= svpwm_pkg::BUS_VOLTAGE_RST;
      max_mod_r     <= svpwm_pkg::MAX_MOD_RST;
      pwm_top_r     <= svpwm_pkg::PWM_TOP_RST;
      d_band_r      <= svpwm_pkg::D_BAND_RST;
      busy_r        <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        unique case (svpwm_pkg::cfg_reg_t'(cfg_addr))
          svpwm_pkg::REG_BUS_VOLTAGE: bus_voltage_r <= cfg_wdata;
          svpwm_pkg::REG_MAX_MOD:     max_mod_r     <= cfg_wdata;
          svpwm_pkg::REG_PWM_TOP:     pwm_top_r     <= cfg_wdata;
          svpwm_pkg::REG_D_BAND:      d_band_r      <= cfg_wdata[9:0];
        endcase
      end
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // input stage
  logic [AB-1:0]      ang_in;
  logic               s0_vld_r;
  logic signed [15:0] s0_vq_r, s0_vd_r;
  logic [AB-1:0]      s0_ang_r;

  if (AB > 16) begin : g_ang_wide
    assign ang_in = {in_elec_angle, {(AB-16){1'b0}}};
  end else if (AB == 16) begin : g_ang_same
    assign ang_in = in_elec_angle;
  end else begin : g_ang_narrow
    assign ang_in = in_elec_angle[15 -: AB];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= accept;
    end
    s0_vq_r  <= in_volt_q;
    s0_vd_r  <= in_volt_d;
    s0_ang_r <= ang_in;
  end

  // dead band test on |Ud|
  logic [16:0] vd_ext, abs_d;
  logic        band, q_pos;

  always_comb begin
    vd_ext = {s0_vd_r[15], s0_vd_r};
    abs_d  = s0_vd_r[15] ? (17'd0 - vd_ext) : vd_ext;
    band   = abs_d < {7'd0, d_band_r};
    q_pos  = (s0_vq_r > 16'sd0);
  end

  // magnitude and angle run side by side
  logic                mag_vld;
  svpwm_pkg::mag_res_t mag_res;
  logic                at_vld;
  logic [31:0]         at_turn;

  svpwm_mag u_mag (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_vld         (s0_vld_r),
    .in_vq          (s0_vq_r),
    .in_vd          (s0_vd_r),
    .bus_voltage    (bus_voltage_r),
    .max_modulation (max_mod_r),
    .out_vld        (mag_vld),
    .out_res        (mag_res)
  );

  svpwm_atan u_atan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s0_vld_r),
    .in_vq    (s0_vq_r),
    .in_vd    (s0_vd_r),
    .out_vld  (at_vld),
    .out_turn (at_turn)
  );

  logic [SW-1:0] sd_r [0:MAG_LAT-1];
  logic [31:0]   zd_r [0:ZD-1];
  logic [ZD-1:0] zv_r;

  always_ff @(posedge clk) begin
    sd_r[0] <= {s0_ang_r, band, q_pos};
    for (int k = 1; k < MAG_LAT; k++) begin
      sd_r[k] <= sd_r[k-1];
    end
    zd_r[0] <= at_turn;
    for (int k = 1; k < ZD; k++) begin
      zd_r[k] <= zd_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zv_r <= '0;
    end else begin
      zv_r <= {zv_r[ZD-2:0], at_vld};
    end
  end

  // stage A: reference vector angle
  logic [AB-1:0]       ang_d, zr, a_ang_nxt;
  logic                band_d, q_pos_d;
  logic [31:0]         zsum;
  logic                a_vld_r;
  logic [AB-1:0]       a_ang_r;
  svpwm_pkg::mag_res_t a_mag_r;

  always_comb begin
    {ang_d, band_d, q_pos_d} = sd_r[MAG_LAT-1];
    zsum = zd_r[ZD-1] + ZRND;
    zr   = zsum[31 -: AB];
    if (band_d) begin
      a_ang_nxt = q_pos_d ? (ang_d + QUARTER) : (ang_d - QUARTER);
    end else begin
      a_ang_nxt = ang_d + zr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= mag_vld;
    end
    a_ang_r <= a_ang_nxt;
    a_mag_r <= mag_res;
  end

  // stage B: sector and angle inside it
  logic [AB+2:0]       a6;
  logic [AB:0]         b_p1_nxt;
  logic                b_vld_r;
  logic [2:0]          b_sec_r;
  logic [AB:0]         b_p1_r, b_p2_r;
  svpwm_pkg::mag_res_t b_mag_r;

  always_comb begin
    a6       = ({3'b000, a_ang_r} << 2) + ({3'b000, a_ang_r} << 1);
    b_p1_nxt = {1'b1, {AB{1'b0}}} - {1'b0, a6[AB-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
    b_sec_r <= a6[AB+2:AB] + 3'd1;
    b_p1_r  <= b_p1_nxt;
    b_p2_r  <= {1'b0, a6[AB-1:0]};
    b_mag_r <= a_mag_r;
  end

  // divide by six: halve, then multiply by the reciprocal of three
  logic [31:0] w1, w2, t32_1, t32_2;
  logic [63:0] pr1, pr2;

  always_comb begin
    w1    = {b_p1_r, {(31-AB){1'b0}}};
    w2    = {b_p2_r, {(31-AB){1'b0}}};
    pr1   = w1 * svpwm_pkg::RECIP3;
    pr2   = w2 * svpwm_pkg::RECIP3;
    t32_1 = {1'b0, pr1[63:33]};
    t32_2 = {1'b0, pr2[63:33]};
  end

  logic        sa_vld, sb_vld;
  logic [30:0] sin_1, sin_2;

  svpwm_sin u_sin_t1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (b_vld_r),
    .in_turn (t32_1),
    .out_vld (sa_vld),
    .out_sin (sin_1)
  );

  svpwm_sin u_sin_t2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (b_vld_r),
    .in_turn (t32_2),
    .out_vld (sb_vld),
    .out_sin (sin_2)
  );

  logic [NW-1:0] sn_r [0:SIN_LAT-1];

  always_ff @(posedge clk) begin
    sn_r[0] <= {b_sec_r, b_mag_r};
    for (int k = 1; k < SIN_LAT; k++) begin
      sn_r[k] <= sn_r[k-1];
    end
  end

  // stage E: times sqrt(3)
  logic [61:0]         pe1, pe2;
  logic                e_vld_r;
  logic [30:0]         e_r1_r, e_r2_r;
  logic [2:0]          e_sec_r;
  svpwm_pkg::mag_res_t e_mag_r;

  always_comb begin
    pe1 = sin_1 * svpwm_pkg::SQRT3_Q30;
    pe2 = sin_2 * svpwm_pkg::SQRT3_Q30;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= sa_vld;
    end
    e_r1_r             <= pe1[60:30];
    e_r2_r             <= pe2[60:30];
    {e_sec_r, e_mag_r} <= sn_r[SIN_LAT-1];
  end

  // stage F: times magnitude
  logic [46:0] pf1, pf2;
  logic        f_vld_r, f_clip_r;
  logic [30:0] f_t1_r, f_t2_r;
  logic [2:0]  f_sec_r;

  always_comb begin
    pf1 = e_r1_r * e_mag_r.mag;
    pf2 = e_r2_r * e_mag_r.mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= e_vld_r;
    end
    f_t1_r   <= pf1[46:16];
    f_t2_r   <= pf2[46:16];
    f_sec_r  <= e_sec_r;
    f_clip_r <= e_mag_r.clipped;
  end

  // stage G: half of the zero-vector time, floored
  logic signed [33:0] t0;
  logic               g_vld_r, g_clip_r;
  logic signed [32:0] g_h0_r;
  logic [30:0]        g_t1_r, g_t2_r;
  logic [2:0]         g_sec_r;

  assign t0 = 34'sh040000000 - $signed({3'b000, f_t1_r}) - $signed({3'b000, f_t2_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else begin
      g_vld_r <= f_vld_r;
    end
    g_h0_r   <= t0[33:1];
    g_t1_r   <= f_t1_r;
    g_t2_r   <= f_t2_r;
    g_sec_r  <= f_sec_r;
    g_clip_r <= f_clip_r;
  end

  // stage H: phase duties per sector, clamped to [0, 1]
  function automatic logic [30:0] clamp_duty(input logic signed [34:0] d);
    logic [30:0] v;
    if (d < 35'sd0) begin
      v = 31'd0;
    end else if (d > 35'sh040000000) begin
      v = 31'h40000000;
    end else begin
      v = d[30:0];
    end
    return v;
  endfunction

  logic signed [34:0] dh, d1, d2, d12;
  logic [30:0]        da, db, dc;
  logic [2:0]         sec_nxt;
  logic               h_vld_r, h_clip_r;
  logic [30:0]        h_da_r, h_db_r, h_dc_r;
  logic [2:0]         h_sec_r;

  always_comb begin
    dh      = {{2{g_h0_r[32]}}, g_h0_r};
    d1      = dh + $signed({4'b0000, g_t1_r});
    d2      = dh + $signed({4'b0000, g_t2_r});
    d12     = d1 + $signed({4'b0000, g_t2_r});
    sec_nxt = g_sec_r;
    case (g_sec_r)
      svpwm_pkg::SEC_1: begin
        da = clamp_duty(dh);  db = clamp_duty(d1);  dc = clamp_duty(d12);
      end
      svpwm_pkg::SEC_2: begin
        da = clamp_duty(d2);  db = clamp_duty(dh);  dc = clamp_duty(d12);
      end
      svpwm_pkg::SEC_3: begin
        da = clamp_duty(d12); db = clamp_duty(dh);  dc = clamp_duty(d1);
      end
      svpwm_pkg::SEC_4: begin
        da = clamp_duty(d12); db = clamp_duty(d2);  dc = clamp_duty(dh);
      end
      svpwm_pkg::SEC_5: begin
        da = clamp_duty(d1);  db = clamp_duty(d12); dc = clamp_duty(dh);
      end
      svpwm_pkg::SEC_6: begin
        da = clamp_duty(dh);  db = clamp_duty(d12); dc = clamp_duty(d2);
      end
      default: begin
        da = 31'd0; db = 31'd0; dc = 31'd0;
        sec_nxt = svpwm_pkg::SEC_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
    end else begin
      h_vld_r <= g_vld_r;
    end
    h_da_r   <= da;
    h_db_r   <= db;
    h_dc_r   <= dc;
    h_sec_r  <= sec_nxt;
    h_clip_r <= g_clip_r;
  end

  // stage I: scale by PWM top
  logic [46:0] pia, pib, pic;
  logic        o_vld_r, o_clip_r;
  logic [15:0] o_a_r, o_b_r, o_c_r;
  logic [2:0]  o_sec_r;

  always_comb begin
    pia = h_da_r * pwm_top_r;
    pib = h_db_r * pwm_top_r;
    pic = h_dc_r * pwm_top_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= h_vld_r;
    end
    o_a_r    <= pia[45:30];
    o_b_r    <= pib[45:30];
    o_c_r    <= pic[45:30];
    o_sec_r  <= h_sec_r;
    o_clip_r <= h_clip_r;
  end

  assign out_valid             = o_vld_r;
  assign out_compare_a         = o_a_r;
  assign out_compare_b         = o_b_r;
  assign out_compare_c         = o_c_r;
  assign out_sector_num        = o_sec_r;
  assign out_magnitude_clipped = o_clip_r;

  // checks
  a_paths_aligned : assert property (@(posedge clk) disable iff (!rst_n)
    zv_r[ZD-1] == mag_vld)
    else $error("angle and magnitude paths out of step");

  a_sin_aligned : assert property (@(posedge clk) disable iff (!rst_n)
    sa_vld == sb_vld)
    else $error("sine lanes out of step");

  a_sector_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sector_num != svpwm_pkg::SEC_NONE &&
                   out_sector_num <= svpwm_pkg::SEC_6))
    else $error("result with sector out of range");

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##PIPE_LAT out_valid)
    else $error("request produced no result at the fixed latency");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for svpwm_duty_from_dq_voltage_core: a table of
// directed requests, then random dq/angle requests across several register
// settings. Each result is checked against a bit-exact predictor, or against the table value for typed rows.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LATENCY   = 91;
  localparam int N_RANDOM  = 850;
  localparam int MAX_CYC   = 600000;

  typedef struct {
    logic [15:0]         cmp_a;
    logic [15:0]         cmp_b;
    logic [15:0]         cmp_c;
    svpwm_pkg::sector_t  sector;
    logic                clipped;
  } duty_t;

  typedef struct {
    logic signed [15:0] vq;
    logic signed [15:0] vd;
    logic [15:0]        ang;
    bit                 typed;
    duty_t              want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_volt_q = '0;
  logic signed [15:0] in_volt_d = '0;
  logic [15:0] in_elec_angle = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic out_valid;
  logic [15:0] out_compare_a, out_compare_b, out_compare_c;
  logic [2:0] out_sector_num;
  logic out_magnitude_clipped;

  svpwm_duty_from_dq_voltage_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_volt_q(in_volt_q), .in_volt_d(in_volt_d), .in_elec_angle(in_elec_angle),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_compare_a(out_compare_a),
    .out_compare_b(out_compare_b), .out_compare_c(out_compare_c),
    .out_sector_num(out_sector_num), .out_magnitude_clipped(out_magnitude_clipped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadow
  logic [15:0] bus_v = svpwm_pkg::BUS_VOLTAGE_RST;
  logic [15:0] mod_lim = svpwm_pkg::MAX_MOD_RST;
  logic [15:0] top_cnt = svpwm_pkg::PWM_TOP_RST;
  logic [9:0]  band_w = svpwm_pkg::D_BAND_RST;

  duty_t duty_q[$];
  duty_t typed_q[$];
  bit    typed_flag_q[$];
  int    n_bad = 0;
  int    n_sent = 0;
  int    n_recv = 0;
  int    n_clip = 0;
  int    n_band = 0;
  int    n_cfg = 0;
  int    cyc = 0;
  bit    next_typed = 0;
  duty_t next_want;
  bit    no_idle = 0;

  logic [31:0] atan_tab [svpwm_pkg::CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // vector angle in 2^-32 turn
  function automatic logic [31:0] vec_angle(int y0, int x0);
    longint x, y, dx, dy;
    logic [31:0] z;
    x = longint'(x0) * 65536;
    y = longint'(y0) * 65536;
    z = '0;
    if (x0 == 0 && y0 == 0) return 32'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < svpwm_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    return z;
  endfunction

  function automatic longint sine_q30(logic [31:0] t);
    longint x, y, z, dx, dy;
    x = longint'(svpwm_pkg::CORDIC_GAIN_Q30);
    y = 0;
    z = longint'({32'd0, t});
    for (int i = 0; i < svpwm_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'({32'd0, atan_tab[i]});
      end else begin
        x += dx; y -= dy; z += longint'({32'd0, atan_tab[i]});
      end
    end
    return (y < 0) ? 0 : y;
  endfunction

  function automatic longint dwell(logic [16:0] phi, logic [15:0] mag);
    logic [63:0] t32, s, r;
    t32 = ({47'd0, phi} << 16) / 6;
    s = 64'(sine_q30(t32[31:0]));
    r = (s * 64'(svpwm_pkg::SQRT3_Q30)) >> 30;
    return longint'((r * 64'(mag)) >> 16);
  endfunction

  function automatic logic [15:0] to_cmp(longint duty);
    logic [63:0] p;
    if (duty < 0) duty = 0;
    if (duty > (64'sd1 <<< 30)) duty = 64'sd1 <<< 30;
    p = (64'(duty) * 64'(top_cnt)) >> 30;
    return p[15:0];
  endfunction

  function automatic duty_t predict_duty(logic signed [15:0] vq, logic signed [15:0] vd,
                                         logic [15:0] raw);
    duty_t r;
    logic [63:0] sq, mraw;
    logic [15:0] ang, mag, busd;
    logic [31:0] z, absd;
    logic [18:0] a6;
    logic [2:0] sec;
    longint t1, t2, h0, ta, tb, tc;
    sq = 64'(longint'(vq) * vq) + 64'(longint'(vd) * vd);
    busd = (bus_v == 0) ? 16'd1 : bus_v;
    mraw = int_sqrt(sq << 32) / busd;
    r.clipped = mraw > mod_lim;
    mag = r.clipped ? mod_lim : mraw[15:0];
    absd = (vd < 0) ? -int'(vd) : int'(vd);
    ang = raw;
    if (absd < band_w) begin
      ang = (vq > 0) ? ang + 16'h4000 : ang - 16'h4000;
    end else begin
      z = vec_angle(vq, vd);
      z = (z + 32'h8000) >> 16;
      ang = ang + z[15:0];
    end
    a6 = 19'(ang * 6);
    sec = a6[18:16] + 3'd1;
    t1 = dwell(17'h10000 - a6[15:0], mag);
    t2 = dwell({1'b0, a6[15:0]}, mag);
    h0 = ((64'sd1 <<< 30) - t1 - t2) >>> 1;
    case (sec)
      3'd1: begin ta = h0; tb = t1 + h0; tc = t1 + t2 + h0; end
      3'd2: begin ta = t2 + h0; tb = h0; tc = t1 + t2 + h0; end
      3'd3: begin ta = t1 + t2 + h0; tb = h0; tc = t1 + h0; end
      3'd4: begin ta = t1 + t2 + h0; tb = t2 + h0; tc = h0; end
      3'd5: begin ta = t1 + h0; tb = t1 + t2 + h0; tc = h0; end
      3'd6: begin ta = h0; tb = t1 + t2 + h0; tc = t2 + h0; end
      default: begin ta = 0; tb = 0; tc = 0; sec = svpwm_pkg::SEC_NONE; end
    endcase
    r.cmp_a = to_cmp(ta);
    r.cmp_b = to_cmp(tb);
    r.cmp_c = to_cmp(tc);
    r.sector = svpwm_pkg::sector_t'(sec);
    return r;
  endfunction

  // request accept and result check
  always @(posedge clk) begin
    duty_t exp_d, got;
    bit typed;
    if (rst_n && start && !busy) begin
      duty_q.push_back(predict_duty(in_volt_q, in_volt_d, in_elec_angle));
      typed_flag_q.push_back(next_typed);
      typed_q.push_back(next_want);
      n_sent++;
      if ((in_volt_d < 0 ? -int'(in_volt_d) : int'(in_volt_d)) < band_w) n_band++;
    end
    if (rst_n && out_valid) begin
      got.cmp_a = out_compare_a;
      got.cmp_b = out_compare_b;
      got.cmp_c = out_compare_c;
      got.sector = svpwm_pkg::sector_t'(out_sector_num);
      got.clipped = out_magnitude_clipped;
      n_recv++;
      if (duty_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result: a=%0d b=%0d c=%0d sec=%0d",
                                  got.cmp_a, got.cmp_b, got.cmp_c, got.sector);
      end else begin
        exp_d = duty_q.pop_front();
        typed = typed_flag_q.pop_front();
        if (typed) exp_d = typed_q.pop_front();
        else void'(typed_q.pop_front());
        if (got.clipped) n_clip++;
        if (got.cmp_a !== exp_d.cmp_a || got.cmp_b !== exp_d.cmp_b ||
            got.cmp_c !== exp_d.cmp_c || got.sector !== exp_d.sector ||
            got.clipped !== exp_d.clipped) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch #%0d: exp a=%0d b=%0d c=%0d sec=%0d clip=%0d",
                     n_recv, exp_d.cmp_a, exp_d.cmp_b, exp_d.cmp_c, exp_d.sector,
                     exp_d.clipped, "  got a=%0d b=%0d c=%0d sec=%0d clip=%0d",
                     got.cmp_a, got.cmp_b, got.cmp_c, got.sector, got.clipped);
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > MAX_CYC) begin
      $display("timeout with %0d results outstanding", duty_q.size());
      $display("** svpwm_duty_from_dq_voltage_core: FAILED **");
      $finish;
    end
  end

  task automatic idle_gap();
    int n, pick;
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 55) n = 0;
    else if (pick < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // drive one request; returns right after its accepting edge
  task automatic send_req(logic signed [15:0] vq, logic signed [15:0] vd, logic [15:0] ang);
    idle_gap();
    start <= 1'b1;
    in_volt_q <= vq;
    in_volt_d <= vd;
    in_elec_angle <= ang;
    forever begin
      @(negedge clk);
      if (!busy) break;
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk);
    while (duty_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // leaves the write enable high; set_regs lowers it after the last write
  task automatic write_reg(svpwm_pkg::cfg_reg_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      svpwm_pkg::REG_BUS_VOLTAGE: bus_v = val;
      svpwm_pkg::REG_MAX_MOD:     mod_lim = val;
      svpwm_pkg::REG_PWM_TOP:     top_cnt = val;
      svpwm_pkg::REG_D_BAND:      band_w = val[9:0];
    endcase
    n_cfg++;
  endtask

  task automatic set_regs(logic [15:0] bv, logic [15:0] mm, logic [15:0] pt, logic [9:0] db);
    write_reg(svpwm_pkg::REG_BUS_VOLTAGE, bv);
    write_reg(svpwm_pkg::REG_MAX_MOD, mm);
    write_reg(svpwm_pkg::REG_PWM_TOP, pt);
    write_reg(svpwm_pkg::REG_D_BAND, {6'd0, db});
    cfg_we <= 1'b0;
  endtask

  task automatic random_reqs(int n);
    logic signed [15:0] vq, vd;
    logic [15:0] ang;
    int kind;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      vq = 16'($urandom);
      vd = 16'($urandom);
      ang = 16'($urandom);
      case (kind)
        0, 1: begin
          // d inside, at or just outside the edge of the dead band
          vd = 16'($urandom_range(0, band_w + 2));
          if ($urandom_range(0, 1)) vd = -vd;
          if ($urandom_range(0, 4) == 0) vq = 0;
        end
        2, 3: begin
          vq = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
          vd = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
        end
        4: ang = $urandom_range(0, 1) ? 16'($urandom_range(0, 15))
                                      : 16'(16'hFFF0 + $urandom_range(0, 15));
        default: ;
      endcase
      send_req(vq, vd, ang);
    end
  endtask

  dir_row_t dir_tab[$];

  initial begin
    dir_row_t row;
    duty_t half;
    half.cmp_a = 16'd899;
    half.cmp_b = 16'd899;
    half.cmp_c = 16'd899;
    half.sector = svpwm_pkg::SEC_5;
    half.clipped = 1'b0;
    // zero vector in the band: angle drops a quarter turn, all phases at half
    dir_tab.push_back('{16'sd0, 16'sd0, 16'd0, 1'b1, half});
    dir_tab.push_back('{16'sd32767, 16'sd0, 16'd0, 1'b0, half});
    dir_tab.push_back('{-16'sd32768, 16'sd0, 16'd0, 1'b0, half});
    dir_tab.push_back('{16'sd0, 16'sd32767, 16'd16384, 1'b0, half});
    dir_tab.push_back('{16'sd0, -16'sd32768, 16'd32768, 1'b0, half});
    dir_tab.push_back('{-16'sd32768, -16'sd32768, 16'hFFFF, 1'b0, half});
    dir_tab.push_back('{16'sd32767, 16'sd32767, 16'h5555, 1'b0, half});
    dir_tab.push_back('{16'sd500, 16'sd9, 16'h1234, 1'b0, half});
    dir_tab.push_back('{16'sd500, -16'sd9, 16'h8000, 1'b0, half});
    dir_tab.push_back('{16'sd500, 16'sd10, 16'hAAAA, 1'b0, half});
    dir_tab.push_back('{-16'sd500, 16'sd5, 16'h2AAA, 1'b0, half});
    dir_tab.push_back('{16'sd0, 16'sd3, 16'hC000, 1'b0, half});
    dir_tab.push_back('{16'sd0, 16'sd200, 16'h0000, 1'b0, half});
    dir_tab.push_back('{16'sd0, -16'sd200, 16'hFFFF, 1'b0, half});
    dir_tab.push_back('{16'sd12000, 16'sd6000, 16'h2AAB, 1'b0, half});
    dir_tab.push_back('{-16'sd7000, 16'sd7000, 16'h7FFF, 1'b0, half});
    dir_tab.push_back('{16'sd1, 16'sd11, 16'hD555, 1'b0, half});
    dir_tab.push_back('{16'sd30000, -16'sd25000, 16'h4000, 1'b0, half});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      next_typed = dir_tab[i].typed;
      next_want = dir_tab[i].want;
      send_req(dir_tab[i].vq, dir_tab[i].vd, dir_tab[i].ang);
      next_typed = 0;
    end
    random_reqs(150);
    wait_drain();

    // extremes: smallest divisor, largest saturation limit, widest top and band
    set_regs(16'd1, 16'hFFFF, 16'hFFFF, 10'd1023);
    foreach (dir_tab[i]) send_req(dir_tab[i].vq, dir_tab[i].vd, dir_tab[i].ang);
    random_reqs(120);
    wait_drain();

    // zero divisor counts as one; zero limit clips every nonzero magnitude; no band
    set_regs(16'd0, 16'd0, 16'd1, 10'd0);
    foreach (dir_tab[i]) send_req(dir_tab[i].vq, dir_tab[i].vd, dir_tab[i].ang);
    random_reqs(100);
    wait_drain();

    set_regs(16'hFFFF, 16'd65535, 16'd1000, 10'd512);
    random_reqs(80);
    wait_drain();

    for (int p = 0; p < 4; p++) begin
      set_regs(16'($urandom_range(1, 30000)), 16'($urandom),
               16'($urandom_range(1, 65535)), 10'($urandom_range(0, 1023)));
      random_reqs(100);
      wait_drain();
    end

    $display("%0d requests, %0d results, %0d register writes;", n_sent, n_recv, n_cfg,
             " %0d clipped, %0d in the d dead band", n_clip, n_band);
    if (n_bad == 0 && duty_q.size() == 0) begin
      $display("** svpwm_duty_from_dq_voltage_core: PASSED **");
    end else begin
      $display("%0d failures, %0d results missing", n_bad, duty_q.size());
      $display("** svpwm_duty_from_dq_voltage_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/svpwm_pkg.sv
sv/svpwm_mag.sv
sv/svpwm_atan.sv
sv/svpwm_sin.sv
sv/svpwm_duty_from_dq_voltage_core.sv
tb/tb_top.sv
